@@ hdl/sfl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sfl_pkg;

  // Ring and sample geometry
  localparam int ADDR_W      = 15;
  localparam int DEPTH       = 1 << ADDR_W;
  localparam int FILL_W      = ADDR_W + 1;
  localparam int SAMPLE_BITS = 16;
  localparam int SUM_W       = SAMPLE_BITS + 1;
  localparam int OUT_W       = SAMPLE_BITS + 1;

  // Oscillator
  localparam int PHASE_BITS  = 24;
  localparam int SINE_BITS   = 10;
  localparam int SINE_POINTS = 1 << SINE_BITS;
  localparam int QTR_POINTS  = SINE_POINTS / 4 + 1;
  localparam int QTR_W       = SINE_BITS - 1;
  localparam int MAG_W       = 15;
  localparam int FACTOR_W    = MAG_W + 1;
  localparam longint unsigned PHASE_RESET =
    ((64'd1 << PHASE_BITS) * 64'd5 + 64'd500) / 64'd1000;

  // Configuration registers
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int BASE_W     = 14;
  localparam int STEP_W     = 20;
  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(8820);
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(34);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE = 2'd0,
    REG_BASE   = 2'd1,
    REG_STEP   = 2'd2
  } cfg_reg_t;

  // Delay arithmetic
  localparam int PROD_W     = BASE_W + FACTOR_W;
  localparam int RND_W      = PROD_W + 1;
  localparam int FRAC_W     = 15;
  localparam int DLY_W      = RND_W - FRAC_W;
  localparam int ROUND_HALF = 1 << (FRAC_W - 1);

  // Output queue
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = 2;
  localparam int OUTQ_CNT_W = OUTQ_PTR_W + 1;

  typedef struct packed {
    logic signed [OUT_W-1:0] left;
    logic signed [OUT_W-1:0] right;
  } frame_t;

  typedef logic [MAG_W-1:0] sine_tab_t [QTR_POINTS];

  // One quarter-wave sine magnitude in Q1.15, by a fixed Taylor series in Q30.
  function automatic logic [MAG_W-1:0] sine_mag(input int unsigned k);
    logic [63:0]        p;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] acc;
    p    = 64'(k) << (32 - SINE_BITS);
    x    = (p * 64'd1686629713) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    acc  = signed'(x);
    term = ((term * x2) >> 30) / 64'd6;
    acc  = acc - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;
    acc  = acc + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;
    acc  = acc - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;
    acc  = acc + signed'(term);
    term = ((term * x2) >> 30) / 64'd110;
    acc  = acc - signed'(term);
    term = ((term * x2) >> 30) / 64'd156;
    acc  = acc + signed'(term);
    if (acc < 0) begin
      acc = 64'sd0;
    end
    v = (unsigned'(acc) * 64'd32767 + 64'd536870912) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[MAG_W-1:0];
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    for (int k = 0; k < QTR_POINTS; k++) begin
      tab[k] = sine_mag(k);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

`default_nettype wire

@@ hdl/sfl_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when the same entry is written in that cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/sfl_lfo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sfl_lfo (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          adv,
  input  wire logic [sfl_pkg::STEP_W-1:0]    phase_step,
  output      logic [sfl_pkg::FACTOR_W-1:0]  factor_r
);

  import sfl_pkg::*;

  logic [PHASE_BITS-1:0] phase_r;
  logic [PHASE_BITS-1:0] phase_nxt;
  logic [SINE_BITS-1:0]  idx;
  logic [QTR_W-1:0]      q;
  logic [SINE_BITS-1:0]  mirrored;
  logic [QTR_W-1:0]      k;
  logic [MAG_W-1:0]      mag;
  logic [FACTOR_W-1:0]   factor_nxt;

  // The sine is kept as a quarter wave; the other three quarters are mirrors.
  always_comb begin
    idx      = phase_r[PHASE_BITS-1 -: SINE_BITS];
    q        = idx[QTR_W-1:0];
    mirrored = SINE_BITS'(SINE_POINTS / 2) - {1'b0, q};
    if (SINE_BITS'(q) > SINE_BITS'(SINE_POINTS / 4)) begin
      k = mirrored[QTR_W-1:0];
    end else begin
      k = q;
    end
    mag = SINE_TAB[k];
    if (idx[SINE_BITS-1]) begin
      factor_nxt = FACTOR_W'(1 << MAG_W) - FACTOR_W'(mag);
    end else begin
      factor_nxt = FACTOR_W'(1 << MAG_W) + FACTOR_W'(mag);
    end
    phase_nxt = phase_r + PHASE_BITS'(phase_step);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PHASE_BITS'(PHASE_RESET);
    end else if (adv) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      factor_r <= factor_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/sfl_outq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sfl_outq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire sfl_pkg::frame_t push_frame,
  input  wire logic            pop,
  output      logic            valid,
  output      sfl_pkg::frame_t head
);

  import sfl_pkg::*;

  frame_t                mem_r [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wr_ptr_r;
  logic [OUTQ_PTR_W-1:0] rd_ptr_r;
  logic [OUTQ_CNT_W-1:0] count_r;
  logic [OUTQ_CNT_W-1:0] count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + OUTQ_CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - OUTQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + OUTQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + OUTQ_PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_frame;
    end
  end

  assign valid = (count_r != '0);
  assign head  = mem_r[rd_ptr_r];

endmodule

`default_nettype wire

@@ hdl/stereo_flanger.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Stereo flanger with a sine oscillator. Each transfer on the input channel
// carries one stereo frame and gives exactly one stereo frame on the output
// channel, in order. The frame is processed as two sub-steps, left then
// right, each of which stores the mono sum in a 32768-entry delay ring,
// looks up the oscillator to set the delay, and mixes the sum with the
// delayed sample (or passes the channel through when bypassed). The ring is
// a single memory with one write and one read port, and each sub-step uses
// that port pair once, so no new frame is taken while the right sub-step of
// the previous one waits to issue. Up to four frames may be outstanding, so
// the input keeps flowing while results wait on a stalled output. Ring
// entries that were never written since reset read as zero through a fill
// count, so no clearing pass is needed and the block is ready straight out
// of reset. Configuration writes are always accepted (cfg_ready is tied
// high) and should only be made while no frame is in flight; writes to an
// unknown register index are ignored.
module stereo_flanger (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Input frames
  input  wire logic                                 in_valid,
  output      logic                                 in_stall,
  input  wire logic signed [sfl_pkg::SAMPLE_BITS-1:0] in_left,
  input  wire logic signed [sfl_pkg::SAMPLE_BITS-1:0] in_right,
  // Output frames
  output      logic                                 out_valid,
  input  wire logic                                 out_stall,
  output      logic signed [sfl_pkg::OUT_W-1:0]     out_left,
  output      logic signed [sfl_pkg::OUT_W-1:0]     out_right,
  // Configuration writes
  input  wire logic                                 cfg_valid,
  output      logic                                 cfg_ready,
  input  wire logic [sfl_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [sfl_pkg::CFG_DATA_W-1:0]       cfg_data
);

  import sfl_pkg::*;

  localparam int PEND_CAP = OUTQ_DEPTH;

  // Configuration registers.
  logic              enable_r;
  logic [BASE_W-1:0] base_r;
  logic [STEP_W-1:0] step_r;

  // Frame bookkeeping: frames accepted but not yet transferred out.
  logic [OUTQ_CNT_W-1:0] pend_r;
  logic                  in_xfer;
  logic                  out_xfer;

  // The right sub-step is held here and issues in the cycle after the left one.
  logic                    hold_v_r;
  logic signed [SAMPLE_BITS-1:0] hold_ch_r;
  logic signed [SUM_W-1:0] hold_sum_r;
  logic signed [SUM_W-1:0] in_sum;

  // Stage A: pointer and fill advance, oscillator lookup.
  logic                          a_v_r;
  logic                          a_last_r;
  logic signed [SUM_W-1:0]       a_sum_r;
  logic signed [SAMPLE_BITS-1:0] a_ch_r;
  logic [ADDR_W-1:0]             wp_r;
  logic [ADDR_W-1:0]             wp_nxt;
  logic [FILL_W-1:0]             fill_r;
  logic [FILL_W-1:0]             fill_nxt;

  // Stage B: delay multiply.
  logic                          b_v_r;
  logic                          b_last_r;
  logic signed [SUM_W-1:0]       b_sum_r;
  logic signed [SAMPLE_BITS-1:0] b_ch_r;
  logic [ADDR_W-1:0]             b_wp_r;
  logic [FILL_W-1:0]             b_fill_r;
  logic [FACTOR_W-1:0]           lfo_factor;

  // Stage C: delay rounding, ring write and read.
  logic                          c_v_r;
  logic                          c_last_r;
  logic signed [SUM_W-1:0]       c_sum_r;
  logic signed [SAMPLE_BITS-1:0] c_ch_r;
  logic [ADDR_W-1:0]             c_wp_r;
  logic [FILL_W-1:0]             c_fill_r;
  logic [PROD_W-1:0]             c_prod_r;
  logic [RND_W-1:0]              c_rnd;
  logic [DLY_W-1:0]              c_dly;
  logic [ADDR_W-1:0]             c_dsat;
  logic [ADDR_W-1:0]             c_raddr;

  // Stage D: mix.
  logic                          d_v_r;
  logic                          d_last_r;
  logic signed [SUM_W-1:0]       d_sum_r;
  logic signed [SAMPLE_BITS-1:0] d_ch_r;
  logic                          d_fwd_r;
  logic                          d_hit_r;
  logic [SUM_W-1:0]              ring_rdata;
  logic signed [SUM_W-1:0]       d_delayed;
  logic signed [SUM_W:0]         d_total;
  logic signed [OUT_W-1:0]       d_y;
  logic signed [OUT_W-1:0]       left_r;

  logic   q_push;
  logic   q_valid;
  frame_t q_frame;
  frame_t q_head;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      base_r   <= BASE_RESET;
      step_r   <= STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLE: enable_r <= cfg_data[0];
        REG_BASE:   base_r   <= cfg_data[BASE_W-1:0];
        REG_STEP:   step_r   <= cfg_data[STEP_W-1:0];
        default:    ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input side. A frame is taken only when there is room for its result in
  // the output queue, counting every frame still in the pipeline.
  // ---------------------------------------------------------------------------
  assign in_stall = hold_v_r || (pend_r == OUTQ_CNT_W'(PEND_CAP));
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign in_sum   = SUM_W'(in_left) + SUM_W'(in_right);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= '0;
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= in_xfer;
      if (in_xfer && !out_xfer) begin
        pend_r <= pend_r + OUTQ_CNT_W'(1);
      end else if (out_xfer && !in_xfer) begin
        pend_r <= pend_r - OUTQ_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      hold_ch_r  <= in_right;
      hold_sum_r <= in_sum;
    end
  end

  // ---------------------------------------------------------------------------
  // Sub-step issue into stage A: left on the transfer, right in the cycle after it.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= in_xfer || hold_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_last_r <= 1'b0;
      a_sum_r  <= in_sum;
      a_ch_r   <= in_left;
    end else begin
      a_last_r <= 1'b1;
      a_sum_r  <= hold_sum_r;
      a_ch_r   <= hold_ch_r;
    end
  end

  // The fill count tracks how many ring entries hold data since reset; an
  // entry further back than that is treated as zero when it is read.
  always_comb begin
    wp_nxt = wp_r + ADDR_W'(1);
    if (fill_r == FILL_W'(DEPTH)) begin
      fill_nxt = fill_r;
    end else begin
      fill_nxt = fill_r + FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      fill_r <= '0;
    end else if (a_v_r) begin
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
    end
  end

  // The oscillator samples its phase before advancing it, as each sub-step
  // uses the phase left by the previous one.
  sfl_lfo u_lfo (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (a_v_r),
    .phase_step (step_r),
    .factor_r   (lfo_factor)
  );

  // ---------------------------------------------------------------------------
  // Stage B: delay = base * (1 + sin), scaled by 2^15.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else begin
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    b_last_r <= a_last_r;
    b_sum_r  <= a_sum_r;
    b_ch_r   <= a_ch_r;
    b_wp_r   <= wp_nxt;
    b_fill_r <= fill_nxt;

    c_last_r <= b_last_r;
    c_sum_r  <= b_sum_r;
    c_ch_r   <= b_ch_r;
    c_wp_r   <= b_wp_r;
    c_fill_r <= b_fill_r;
    c_prod_r <= PROD_W'(base_r) * PROD_W'(lfo_factor);
  end

  // ---------------------------------------------------------------------------
  // Stage C: round the delay to whole samples, saturate it to the ring, and
  // work out the read slot. The write of this sub-step and its read share the
  // cycle, so a later sub-step can never overwrite a slot before it is read.
  // ---------------------------------------------------------------------------
  always_comb begin
    c_rnd = RND_W'(c_prod_r) + RND_W'(ROUND_HALF);
    c_dly = c_rnd[RND_W-1:FRAC_W];
    if (32'(c_dly) > 32'(DEPTH - 1)) begin
      c_dsat = ADDR_W'(DEPTH - 1);
    end else begin
      c_dsat = ADDR_W'(c_dly);
    end
    c_raddr = c_wp_r - c_dsat;
  end

  sfl_ram #(
    .WIDTH (SUM_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (c_v_r),
    .waddr (c_wp_r),
    .wdata (c_sum_r),
    .raddr (c_raddr),
    .rdata (ring_rdata)
  );

  always_ff @(posedge clk) begin
    d_last_r <= c_last_r;
    d_sum_r  <= c_sum_r;
    d_ch_r   <= c_ch_r;
    d_fwd_r  <= (c_dsat == '0);
    d_hit_r  <= (FILL_W'(c_dsat) < c_fill_r);
  end

  // ---------------------------------------------------------------------------
  // Stage D: a zero delay reads back the sum written in the same sub-step,
  // which the memory does not yet return, so it is forwarded here.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (d_fwd_r) begin
      d_delayed = d_sum_r;
    end else if (d_hit_r) begin
      d_delayed = signed'(ring_rdata);
    end else begin
      d_delayed = '0;
    end
    d_total = (SUM_W + 1)'(d_sum_r) + (SUM_W + 1)'(d_delayed);
    if (enable_r) begin
      d_y = d_total[SUM_W:1];
    end else begin
      d_y = OUT_W'(d_ch_r);
    end
  end

  always_ff @(posedge clk) begin
    if (d_v_r && !d_last_r) begin
      left_r <= d_y;
    end
  end

  assign q_push        = d_v_r && d_last_r;
  assign q_frame.left  = left_r;
  assign q_frame.right = d_y;

  sfl_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_frame (q_frame),
    .pop        (out_xfer),
    .valid      (q_valid),
    .head       (q_head)
  );

  assign out_valid = q_valid;
  assign out_left  = q_head.left;
  assign out_right = q_head.right;

`ifndef ASSERT_OFF
  // Outstanding frames never exceed the room in the output queue.
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= OUTQ_CNT_W'(PEND_CAP))
    else $error("outstanding frame count above queue capacity");

  // A left sub-step is always followed at once by its right sub-step.
  a_pair_issue: assert property (@(posedge clk) disable iff (!rst_n)
    a_v_r && !a_last_r |=> a_v_r && a_last_r)
    else $error("right sub-step did not follow left sub-step");

  // A finished frame belongs to a frame still counted as outstanding.
  a_push_pending: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> pend_r != '0)
    else $error("frame completed with none outstanding");

  // Results on offer are always covered by the outstanding count.
  a_out_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != '0)
    else $error("result offered with none outstanding");
`endif

endmodule

`default_nettype wire

@@ bench/stereo_flanger_tb.sv @@
`timescale 1ns / 1ps

// Bench for the stereo flanger. Frames are pushed through the input channel
// while an independent predictor, kept alongside the block, works out the
// frame that each input transfer should produce. The result channel is
// watched on every clock edge and each output transfer is compared field by
// field with the oldest prediction still waiting. The run starts with short
// directed tests and then moves to randomised traffic under four mixes of
// sender idling and receiver stalling.
module stereo_flanger_tb;

  // The delay ring, the write pointer and the oscillator phase all wrap at
  // their natural widths, so the predictor uses vectors of those widths.
  localparam int RING_AW   = sfl_pkg::ADDR_W;
  localparam int RING_SIZE = 1 << RING_AW;
  localparam int ACC_W     = sfl_pkg::PHASE_BITS;
  localparam int LUT_BITS  = 10;
  localparam int LUT_SIZE  = 1 << LUT_BITS;
  localparam int SMP_W     = sfl_pkg::SAMPLE_BITS;
  localparam int DATA_W    = sfl_pkg::CFG_DATA_W;
  localparam int IDX_W     = sfl_pkg::CFG_IDX_W;

  // Register values straight after reset.
  localparam logic [13:0]      BASE_AT_RESET  = 14'd8820;
  localparam logic [19:0]      STEP_AT_RESET  = 20'd34;
  localparam logic [ACC_W-1:0] PHASE_AT_RESET = ACC_W'(((64'd1 << ACC_W) * 64'd5 + 64'd500) /
                                                       64'd1000);

  // Index three names no register; a write there must leave everything alone.
  localparam logic [IDX_W-1:0] REG_NONE = 2'd3;

  // A whole run with no transfer of any kind for this many cycles means the
  // block has locked up.
  localparam int QUIET_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n;

  logic                     in_valid;
  logic                     in_stall;
  logic signed [SMP_W-1:0]  in_left;
  logic signed [SMP_W-1:0]  in_right;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [sfl_pkg::OUT_W-1:0] out_left;
  logic signed [sfl_pkg::OUT_W-1:0] out_right;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [IDX_W-1:0]         cfg_index;
  logic [DATA_W-1:0]        cfg_data;

  stereo_flanger uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_left   (in_left),
    .in_right  (in_right),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_left  (out_left),
    .out_right (out_right),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state: its own copy of the ring, pointer, phase and registers.
  logic signed [sfl_pkg::SUM_W-1:0] ring_mem [RING_SIZE];
  logic [RING_AW-1:0]               wr_ptr;
  logic [ACC_W-1:0]                 lfo_acc;
  logic                             flange_on;
  logic [13:0]                      centre_delay;
  logic [19:0]                      lfo_step;
  int                               sine_lut [LUT_SIZE];

  // Frames still owed by the block, oldest first.
  sfl_pkg::frame_t expected_frames [$];

  int error_count    = 0;
  int frames_sent    = 0;
  int frames_checked = 0;
  int settings_made  = 0;
  int quiet_cycles   = 0;

  // Percentages of cycles in which the sender holds off and the receiver
  // stalls; each random phase sets the mix that it wants.
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // One sine table entry in Q1.15. The angle is folded into the first
  // quadrant and a Taylor sum in Q30 runs through the thirteenth power.
  function automatic int sine_point(input int unsigned k);
    longint unsigned p;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned v;
    longint          acc;
    bit              neg;
    p   = (longint'(k) << 32) / LUT_SIZE;
    neg = 1'b0;
    if (p >= (64'd1 << 31)) begin
      neg = 1'b1;
      p   = p - (64'd1 << 31);
    end
    if (p > (64'd1 << 30)) begin
      p = (64'd1 << 31) - p;
    end
    x    = (p * 64'd1686629713) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 64'sd0;
    end
    v = (longint'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return neg ? -int'(v) : int'(v);
  endfunction

  // Put the predictor into its reset state and build the sine table.
  task automatic reset_predictor();
    for (int k = 0; k < LUT_SIZE; k++) begin
      sine_lut[k] = sine_point(k);
    end
    for (int a = 0; a < RING_SIZE; a++) begin
      ring_mem[a] = '0;
    end
    wr_ptr       = '0;
    lfo_acc      = PHASE_AT_RESET;
    flange_on    = 1'b0;
    centre_delay = BASE_AT_RESET;
    lfo_step     = STEP_AT_RESET;
  endtask

  // Run the two channel sub-steps of one frame, left then right, and return
  // the frame that the block should produce.
  function automatic sfl_pkg::frame_t flange_frame(input logic signed [SMP_W-1:0] l,
                                                   input logic signed [SMP_W-1:0] r);
    sfl_pkg::frame_t    res;
    int                 mono;
    int                 ch [2];
    int                 s;
    int                 y;
    longint             dly;
    logic [RING_AW-1:0] rd;
    ch[0] = int'(l);
    ch[1] = int'(r);
    mono  = ch[0] + ch[1];
    for (int c = 0; c < 2; c++) begin
      wr_ptr           = wr_ptr + 1'b1;
      ring_mem[wr_ptr] = sfl_pkg::SUM_W'(mono);
      s   = sine_lut[lfo_acc[ACC_W-1 -: LUT_BITS]];
      dly = (longint'(centre_delay) * longint'(32768 + s) + 16384) >>> 15;
      // A delay past the end of the ring is held at the oldest entry.
      if (dly > RING_SIZE - 1) begin
        dly = RING_SIZE - 1;
      end
      lfo_acc = lfo_acc + ACC_W'(lfo_step);
      rd      = wr_ptr - RING_AW'(dly);
      if (flange_on) begin
        y = (mono + int'(ring_mem[rd])) >>> 1;
      end else begin
        y = ch[c];
      end
      if (c == 0) begin
        res.left = sfl_pkg::OUT_W'(y);
      end else begin
        res.right = sfl_pkg::OUT_W'(y);
      end
    end
    return res;
  endfunction

  // Offer one frame, holding off first for as long as the sender mix asks.
  // Valid is left high after the transfer so that a frame that follows at
  // once goes out back to back; whoever stops sending lowers it.
  task automatic send_frame(input logic signed [SMP_W-1:0] l,
                            input logic signed [SMP_W-1:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_left  <= l;
    in_right <= r;
    do @(posedge clk); while (in_stall);
    expected_frames.push_back(flange_frame(l, r));
    frames_sent++;
  endtask

  // Stop sending and wait until every frame owed has come out. Since each
  // frame gives exactly one result, the block is idle once this returns.
  task automatic drain_frames();
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // One register transfer. Valid stays high so that writes can follow back
  // to back; apply_setting lowers it after the last one.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    // Bits above each register's width are dropped by the block.
    case (idx)
      sfl_pkg::REG_ENABLE: flange_on    = data[0];
      sfl_pkg::REG_BASE:   centre_delay = data[13:0];
      sfl_pkg::REG_STEP:   lfo_step     = data[19:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [DATA_W-1:0] en,
                               input logic [DATA_W-1:0] base,
                               input logic [DATA_W-1:0] step);
    drain_frames();
    write_reg(sfl_pkg::REG_ENABLE, en);
    write_reg(sfl_pkg::REG_BASE, base);
    write_reg(sfl_pkg::REG_STEP, step);
    cfg_valid <= 1'b0;
    settings_made++;
  endtask

  // Random sample, with the two extremes and zero turning up often.
  function automatic logic signed [SMP_W-1:0] rand_sample();
    case ($urandom_range(11))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      default: return SMP_W'($urandom);
    endcase
  endfunction

  // The result side: stall at random, check every output transfer against
  // the oldest prediction, and flag anything that arrives unannounced.
  always @(posedge clk) begin
    sfl_pkg::frame_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        $error("unexpected output frame: out_left %0d, out_right %0d", out_left, out_right);
        error_count++;
      end else begin
        want = expected_frames.pop_front();
        if (out_left !== want.left) begin
          $error("out_left mismatch: expected %0d, actual %0d", want.left, out_left);
          error_count++;
        end
        if (out_right !== want.right) begin
          $error("out_right mismatch: expected %0d, actual %0d", want.right, out_right);
          error_count++;
        end
        frames_checked++;
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Straight out of reset the block bypasses, so every output must be the
  // matching input. Full-scale samples of both signs go through here, and
  // the ring keeps filling even though nothing is being mixed.
  task automatic test_bypass_extremes();
    send_frame(16'sh7FFF, 16'sh7FFF);
    send_frame(16'sh8000, 16'sh8000);
    send_frame(16'sh7FFF, 16'sh8000);
    send_frame(16'sh8000, 16'sh7FFF);
    send_frame(16'sh0000, 16'shFFFF);
    send_frame(16'sh5555, 16'shAAAA);
  endtask

  // A centre delay of zero makes the delay zero whatever the oscillator
  // says, so each sub-step reads back the sum it has just written. With
  // full-scale inputs this also drives the outputs to their extremes.
  task automatic test_zero_delay();
    apply_setting(20'd1, 20'd0, 20'hFFFFF);
    send_frame(16'sh7FFF, 16'sh7FFF);
    send_frame(16'sh8000, 16'sh8000);
    send_frame(16'sh8000, 16'sh7FFF);
    send_frame(16'sh0001, 16'sh0000);
    send_frame(16'shFFFF, 16'sh0000);
  endtask

  // A write to the unused index must change nothing, and data bits above a
  // register's width must be dropped. A frozen oscillator and a short delay
  // make the mix read back frames written only a few sub-steps earlier.
  task automatic test_register_writes();
    drain_frames();
    write_reg(REG_NONE, 20'hFFFFF);
    write_reg(sfl_pkg::REG_ENABLE, 20'hFFFFE);
    cfg_valid <= 1'b0;
    send_frame(16'sh1234, 16'sh4321);
    send_frame(16'sh8000, 16'sh0001);
    apply_setting(20'hFFFFF, 20'hFC005, 20'd0);
    send_frame(16'sh7FFF, 16'sh0000);
    send_frame(16'sh8000, 16'sh8000);
    send_frame(16'sh2000, 16'shE000);
    send_frame(16'sh7FFF, 16'sh7FFF);
  endtask

  // The largest centre delay with the fastest oscillator swings the delay
  // close to the full ring, far beyond anything written so far.
  task automatic test_longest_delay();
    apply_setting(20'd1, 20'h03FFF, 20'hFFFFF);
    send_frame(16'sh7FFF, 16'sh8000);
    send_frame(16'sh8000, 16'sh8000);
    send_frame(16'sh0F0F, 16'shF0F0);
    send_frame(16'sh7FFF, 16'sh7FFF);
  endtask

  // One idling mix, run under two random settings. Centre delays are mostly
  // short so that the mix reads back frames that really were written.
  task automatic random_phase(input int idle_in, input int idle_out, input int frames,
                              input bit hold_off);
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] step;
    send_idle_pct = idle_in;
    stall_pct     = idle_out;
    for (int k = 0; k < 2; k++) begin
      base = ($urandom_range(3) == 0) ? DATA_W'($urandom_range(16383)) :
                                        DATA_W'($urandom_range(400));
      step = ($urandom_range(3) == 0) ? DATA_W'($urandom_range(64)) : DATA_W'($urandom);
      apply_setting(DATA_W'($urandom_range(5) != 0), base, step);
      for (int n = 0; n < frames; n++) begin
        // In a run with hold_off set, the sender waits once for the block to empty completely.
        if (hold_off && k == 0 && n == frames / 2) begin
          drain_frames();
        end
        send_frame(rand_sample(), rand_sample());
      end
    end
  endtask

  task automatic test_random_traffic();
    random_phase(0, 0, 56, 1'b0);
    random_phase(88, 0, 56, 1'b0);
    random_phase(0, 88, 56, 1'b1);
    random_phase(29, 29, 56, 1'b0);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_left   = '0;
    in_right  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    reset_predictor();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_bypass_extremes();
    test_zero_delay();
    test_register_writes();
    test_longest_delay();
    test_random_traffic();

    // Let everything owed come out, then give the block time to show any
    // frame that nobody asked for.
    drain_frames();
    repeat (20) @(posedge clk);

    $display("Sent %0d frames and checked %0d results under %0d register settings.",
             frames_sent, frames_checked, settings_made);
    $display("Covered bypass, zero and longest delays, register masking and four idling mixes.");
    if (error_count == 0 && expected_frames.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ stereo_flanger.f @@
hdl/sfl_pkg.sv
hdl/sfl_ram.sv
hdl/sfl_lfo.sv
hdl/sfl_outq.sv
hdl/stereo_flanger.sv
bench/stereo_flanger_tb.sv
